>>> rtl/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// shared types and constants of the bit-pair run-length plane decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

    // plane geometry
    localparam int TILE_BITS      = 64;
    localparam int PAIRS_PER_TILE = TILE_BITS / 2;
    localparam int PAIR_SHIFT     = $clog2(PAIRS_PER_TILE);

    // field widths
    localparam int PAIR_W   = 2;
    localparam int COUNT_W  = 13;
    localparam int TILE_W   = 4;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // default for the prefix saturation limit
    localparam int DEFAULT_MAX_PREFIX = 16;

    // register reset values
    localparam logic [TILE_W-1:0] RST_WIDTH_TILES  = 4'd7;
    localparam logic [TILE_W-1:0] RST_HEIGHT_TILES = 4'd7;
    localparam logic              RST_FIRST_IS_RUN = 1'b1;

    // the pair that fills runs and ends direct packets
    localparam logic [PAIR_W-1:0] PAIR_ZERO = 2'b00;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_TILES  = 2'd0,
        REG_HEIGHT_TILES = 2'd1,
        REG_FIRST_IS_RUN = 2'd2
    } t_reg_idx;

    // packet phase: prefix bit / first pair bit, or body
    typedef enum logic {
        PH_HEAD = 1'b0,
        PH_BODY = 1'b1
    } t_phase;

    // configuration write
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    // one result item
    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
        logic [PAIR_W-1:0]  pair;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/rbp_decode_core.sv
// ----------------------------------------------------------------------------
// rbp_decode_core
// configuration registers and per-bit packet decode state; each accepted
// beat updates the state and may produce one result
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_decode_core #(
    parameter int MAX_PREFIX = rbp_pkg::DEFAULT_MAX_PREFIX
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rbp_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_step,
    input  wire logic             i_data_bit,
    output logic                  o_res_valid,
    output rbp_pkg::t_result      o_res
);
    import rbp_pkg::*;

    localparam int PREFIX_W = $clog2(MAX_PREFIX + 1);
    localparam int LEFT_W   = $clog2(MAX_PREFIX + 2);
    localparam int ACC_W    = MAX_PREFIX + 1;
    localparam int SUM_W    = ACC_W + 1;
    localparam int CMP_W    = (SUM_W > COUNT_W) ? SUM_W : COUNT_W;

    // configuration
    logic [TILE_W-1:0] r_width, n_width;
    logic [TILE_W-1:0] r_height, n_height;
    logic              r_first, n_first;

    // decode state
    logic                r_started, n_started;
    logic [COUNT_W-1:0]  r_pairs, n_pairs;
    logic                r_is_run, n_is_run;
    t_phase              r_phase, n_phase;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [ACC_W-1:0]    r_len, n_len;
    logic [ACC_W-1:0]    r_val, n_val;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_held, n_held;
    logic                r_full, n_full;

    logic [2*TILE_W-1:0] tiles;
    logic [COUNT_W-1:0]  total;
    logic [COUNT_W-1:0]  remaining;
    logic                overfull;
    logic                live;
    logic [ACC_W-1:0]    len_mask;
    logic [ACC_W-1:0]    val_shift;
    logic [CMP_W-1:0]    run_count;
    logic [PAIR_W-1:0]   pair;

    // plane size in pairs
    assign tiles     = r_width * r_height;
    assign total     = COUNT_W'({tiles, {PAIR_SHIFT{1'b0}}});
    assign remaining = total - r_pairs;
    assign overfull  = (r_pairs >= total);
    assign live      = i_step && !r_full && !overfull;

    // run length from prefix: ones in bits 1..prefix
    always_comb begin
        for (int i = 0; i < ACC_W; i++) begin
            len_mask[i] = (i >= 1) && (i <= int'(r_prefix));
        end
    end

    assign val_shift = {r_val[ACC_W-2:0], i_data_bit};
    assign run_count = CMP_W'(r_len) + CMP_W'(val_shift) + CMP_W'(1);
    assign pair      = {r_held, i_data_bit};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (live) begin
            case (r_phase)
                PH_HEAD: begin
                    if (!r_is_run || !i_data_bit) begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (!r_is_run || r_left == LEFT_W'(1)) begin
                        n_phase = PH_HEAD;
                    end
                end
                default: n_phase = PH_HEAD;
            endcase
        end
    end

    // datapath, result and configuration
    always_comb begin
        logic [CMP_W-1:0] cnt;
        logic             emit;
        logic             end_pkt;

        n_width   = r_width;
        n_height  = r_height;
        n_first   = r_first;
        n_started = r_started;
        n_pairs   = r_pairs;
        n_is_run  = r_is_run;
        n_prefix  = r_prefix;
        n_len     = r_len;
        n_val     = r_val;
        n_left    = r_left;
        n_held    = r_held;
        n_full    = r_full;
        cnt       = CMP_W'(1);
        emit      = 1'b0;
        end_pkt   = 1'b0;
        o_res_valid = 1'b0;
        o_res.pair  = PAIR_ZERO;
        o_res.count = '0;
        o_res.done  = 1'b0;

        if (i_step) begin
            n_started = 1'b1;
        end

        // bit decode
        if (i_step && !r_full && overfull) begin
            n_full = 1'b1;
        end else if (live) begin
            if (r_is_run) begin
                if (r_phase == PH_HEAD) begin
                    if (i_data_bit) begin
                        if (r_prefix < PREFIX_W'(MAX_PREFIX)) begin
                            n_prefix = r_prefix + PREFIX_W'(1);
                        end
                    end else begin
                        n_len  = len_mask;
                        n_val  = '0;
                        n_left = LEFT_W'(r_prefix) + LEFT_W'(1);
                    end
                end else begin
                    n_val  = val_shift;
                    n_left = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        cnt     = run_count;
                        emit    = 1'b1;
                        end_pkt = 1'b1;
                    end
                end
            end else begin
                if (r_phase == PH_HEAD) begin
                    n_held = i_data_bit;
                end else if (pair == PAIR_ZERO) begin
                    end_pkt = 1'b1;
                end else begin
                    o_res.pair = pair;
                    emit       = 1'b1;
                end
            end
        end

        if (end_pkt) begin
            n_is_run = !r_is_run;
            n_prefix = '0;
            n_left   = '0;
        end

        // emit with clamp to the remaining pairs
        if (emit) begin
            o_res_valid = 1'b1;
            if (cnt >= CMP_W'(remaining)) begin
                o_res.count = remaining;
                o_res.done  = 1'b1;
                n_full      = 1'b1;
            end else begin
                o_res.count = COUNT_W'(cnt);
            end
            n_pairs = r_pairs + o_res.count;
        end

        // register writes
        if (i_cfg.we) begin
            case (t_reg_idx'(i_cfg.idx))
                REG_WIDTH_TILES:  n_width  = i_cfg.data;
                REG_HEIGHT_TILES: n_height = i_cfg.data;
                REG_FIRST_IS_RUN: begin
                    n_first = i_cfg.data[0];
                    if (!r_started) begin
                        n_is_run = i_cfg.data[0];
                    end
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH_TILES;
            r_height  <= RST_HEIGHT_TILES;
            r_first   <= RST_FIRST_IS_RUN;
            r_started <= 1'b0;
            r_pairs   <= '0;
            r_is_run  <= RST_FIRST_IS_RUN;
            r_phase   <= PH_HEAD;
            r_prefix  <= '0;
            r_len     <= '0;
            r_val     <= '0;
            r_left    <= '0;
            r_held    <= 1'b0;
            r_full    <= 1'b0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_first   <= n_first;
            r_started <= n_started;
            r_pairs   <= n_pairs;
            r_is_run  <= n_is_run;
            r_phase   <= n_phase;
            r_prefix  <= n_prefix;
            r_len     <= n_len;
            r_val     <= n_val;
            r_left    <= n_left;
            r_held    <= n_held;
            r_full    <= n_full;
        end
    end

    // a full plane gives no further results
    a_full_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> !o_res_valid)
        else $error("result produced after plane completed");

    // a final result fills the plane exactly
    a_done_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.done) |=> (r_full && r_pairs == $past(total)))
        else $error("final result does not fill the plane");

    // every result repeats at least once
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.count != '0))
        else $error("result with zero repeat count");

    // run body always has value bits pending
    a_run_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_is_run && r_phase == PH_BODY) |-> (r_left != '0))
        else $error("run body without pending value bits");

endmodule

`default_nettype wire

>>> rtl/rbp_out_reg.sv
// ----------------------------------------------------------------------------
// rbp_out_reg
// result register on the master side; takes a new result in the cycle the
// held one leaves
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire rbp_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    output rbp_pkg::t_result      o_res,
    input  wire logic             i_take
);
    import rbp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // free when empty or being drained
    assign o_ready = !r_valid || i_take;
    assign n_valid = i_load || (r_valid && !i_take);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> rtl/rle_bit_pair_plane_decoder.sv
// ----------------------------------------------------------------------------
// rle_bit_pair_plane_decoder
// rebuilds one bit plane, as runs of bit pairs, from a run-length stream
// ----------------------------------------------------------------------------
// The decoder takes one compressed stream bit per beat and accepts a beat in
// every cycle in which the output register is empty or is drained in the same
// cycle; a bit that completes a run or a non-zero direct pair yields one
// result beat in the next cycle, held in the output register. The plane holds
// width_tiles*height_tiles*32 pairs; the result that completes it carries
// tlast, and all later bits are taken and dropped until reset. Runs are
// clamped to the pairs left in the plane. Registers are written through the
// plain write port while the stream idles; the block leaves this to the user.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_bit_pair_plane_decoder #(
    parameter int MAX_PREFIX = rbp_pkg::DEFAULT_MAX_PREFIX
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [rbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbp_pkg::CFG_W-1:0]     i_cfg_data,
    // stream bits in
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [rbp_pkg::S_DATA_W-1:0]  i_s_tdata,   // [0] data_bit
    // results out
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [rbp_pkg::M_DATA_W-1:0]       o_m_tdata,   // [1:0] pair_value,
                                                            // [14:2] repeat_count
    output logic                               o_m_tlast    // plane_done
);
    import rbp_pkg::*;

    t_cfg_wr cfg;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // beat accepted
    assign step = i_s_tvalid && o_s_tready;

    // decode state
    rbp_decode_core #(
        .MAX_PREFIX(MAX_PREFIX)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_step     (step),
        .i_data_bit (i_s_tdata[0]),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // result register
    rbp_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (res_valid),
        .i_res  (res),
        .o_ready(o_s_tready),
        .o_valid(o_m_tvalid),
        .o_res  (out_res),
        .i_take (i_m_tready)
    );

    // pack result beat
    assign o_m_tdata = {1'b0, out_res.count, out_res.pair};
    assign o_m_tlast = out_res.done;

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bit-pair run-length plane decoder
// ----------------------------------------------------------------------------
// Feeds the compressed stream one bit per beat. A short table of hand-picked
// beats comes first: direct pairs, the empty direct packet and small runs.
// Random phases follow, mostly well-formed packets with some noise, under
// several plane sizes. The run ends in one of four ways that close the plane:
// a saturated prefix, a shrunk plane, a zero size, or a natural fill. After
// that the stream is fed on to show that it is dropped. Each result beat is
// compared field by field with a behavioral decoder kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rbp_pkg::*;

    localparam int PREFIX_CAP     = DEFAULT_MAX_PREFIX;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASE_BITS     = 135;
    localparam int NUM_PHASES     = 5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic                 o_m_tlast;

    rle_bit_pair_plane_decoder #(
        .MAX_PREFIX (PREFIX_CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // one row of the opening table
    typedef struct {
        logic    b;
        bit      typed;
        t_result want;
    } t_stim_row;

    t_stim_row opening_rows[$];
    t_result   pair_runs_q[$];
    t_result   run_expect;

    // decoder copy: configuration
    logic [TILE_W-1:0] cfg_width;
    logic [TILE_W-1:0] cfg_height;
    logic              cfg_run_first;

    // decoder copy: state
    logic [COUNT_W-1:0] plane_pairs_done;
    logic               run_packet_now;
    t_phase             pkt_phase;
    logic [4:0]         prefix_count;
    logic [16:0]        run_base;
    logic [16:0]        run_value;
    logic [4:0]         value_bits_due;
    logic               first_pair_bit;
    logic               plane_complete;
    logic               stream_seen;

    int mismatches;
    int idle_cycles;
    int bits_live;
    bit tx_gaps;
    bit rx_stalls;
    bit hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want_v);
        mismatches++;
    endtask

    // switch to the other packet kind
    function automatic void close_packet();
        run_packet_now = ~run_packet_now;
        pkt_phase      = PH_HEAD;
        prefix_count   = '0;
        value_bits_due = '0;
    endfunction

    // one result, clamped to the pairs left in the plane
    function automatic bit emit_pair(input logic [PAIR_W-1:0] pr, input int cnt,
                                     input int plane_pairs, output t_result res);
        int left;
        int n;
        left = plane_pairs - int'(plane_pairs_done);
        n    = cnt;
        res.done = (cnt >= left);
        if (res.done) begin
            n = left;
            plane_complete = 1'b1;
        end
        plane_pairs_done = plane_pairs_done + n[COUNT_W-1:0];
        res.pair  = pr;
        res.count = n[COUNT_W-1:0];
        return 1'b1;
    endfunction

    // decode one stream bit, 1 when it yields a result
    function automatic bit decode_bit(input logic b, output t_result res);
        int                plane_pairs;
        int                run_len;
        logic [PAIR_W-1:0] pr;
        res = '0;
        plane_pairs = int'(cfg_width) * int'(cfg_height) * PAIRS_PER_TILE;
        stream_seen = 1'b1;
        if (plane_complete)
            return 1'b0;
        if (int'(plane_pairs_done) >= plane_pairs) begin
            plane_complete = 1'b1;
            return 1'b0;
        end
        if (run_packet_now) begin
            // prefix of ones, saturating
            if (pkt_phase == PH_HEAD) begin
                if (b) begin
                    if (prefix_count < PREFIX_CAP)
                        prefix_count = prefix_count + 5'd1;
                end else begin
                    run_base       = ((17'd1 << prefix_count) - 17'd1) << 1;
                    run_value      = '0;
                    value_bits_due = prefix_count + 5'd1;
                    pkt_phase      = PH_BODY;
                end
                return 1'b0;
            end
            // value bits, msb first
            run_value      = {run_value[15:0], b};
            value_bits_due = value_bits_due - 5'd1;
            if (value_bits_due != 0)
                return 1'b0;
            run_len = int'(run_base) + int'(run_value) + 1;
            close_packet();
            return emit_pair(PAIR_ZERO, run_len, plane_pairs, res);
        end
        // direct packet: pairs until 00
        if (pkt_phase == PH_HEAD) begin
            first_pair_bit = b;
            pkt_phase      = PH_BODY;
            return 1'b0;
        end
        pkt_phase = PH_HEAD;
        pr = {first_pair_bit, b};
        if (pr == PAIR_ZERO) begin
            close_packet();
            return 1'b0;
        end
        return emit_pair(pr, 1, plane_pairs, res);
    endfunction

    function automatic void apply_reg_write(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_WIDTH_TILES:  cfg_width  = val;
            REG_HEIGHT_TILES: cfg_height = val;
            REG_FIRST_IS_RUN: begin
                cfg_run_first = val[0];
                if (!stream_seen)
                    run_packet_now = val[0];
            end
            default: ;
        endcase
    endfunction

    // table rows
    function automatic void row_plain(input logic b);
        t_stim_row r;
        r.b     = b;
        r.typed = 1'b0;
        r.want  = '0;
        opening_rows.push_back(r);
    endfunction

    function automatic void row_typed(input logic b, input logic [PAIR_W-1:0] pr,
                                      input logic [COUNT_W-1:0] cnt);
        t_stim_row r;
        r.b          = b;
        r.typed      = 1'b1;
        r.want.done  = 1'b0;
        r.want.count = cnt;
        r.want.pair  = pr;
        opening_rows.push_back(r);
    endfunction

    // register write, only while the stream idles
    task automatic cfg_write(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_reg_write(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one bit; the beat is taken at the edge after a ready negedge
    task automatic send_bit(input logic b, input bit use_typed, input t_result typed);
        t_result got;
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W-1){1'b0}}, b};
        @(negedge i_clk);
        while (!o_s_tready)
            @(negedge i_clk);
        if (!plane_complete)
            bits_live++;
        if (decode_bit(b, got) && !use_typed)
            pair_runs_q.push_back(got);
        if (use_typed)
            pair_runs_q.push_back(typed);
        @(posedge i_clk);
    endtask

    // one packet: mostly well formed, some noise
    task automatic send_packet();
        int                r;
        int                n;
        logic [PAIR_W-1:0] pr;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) send_bit($urandom_range(0, 1), 1'b0, '0);
        end else if (pkt_phase != PH_HEAD || prefix_count != 0) begin
            send_bit($urandom_range(0, 1), 1'b0, '0);
        end else if (run_packet_now) begin
            r = $urandom_range(0, 99);
            n = (r < 30) ? 0 : (r < 60) ? 1 : (r < 80) ? 2 : (r < 92) ? 3 : (r < 97) ? 4 : 5;
            repeat (n) send_bit(1'b1, 1'b0, '0);
            send_bit(1'b0, 1'b0, '0);
            repeat (n + 1) send_bit($urandom_range(0, 1), 1'b0, '0);
        end else begin
            repeat ($urandom_range(0, 6)) begin
                pr = PAIR_W'($urandom_range(1, 3));
                send_bit(pr[1], 1'b0, '0);
                send_bit(pr[0], 1'b0, '0);
            end
            send_bit(1'b0, 1'b0, '0);
            send_bit(1'b0, 1'b0, '0);
        end
    endtask

    // zeros until a fresh run packet starts
    task automatic align_to_run();
        while (!(run_packet_now && pkt_phase == PH_HEAD && prefix_count == 0) && !plane_complete)
            send_bit(1'b0, 1'b0, '0);
    endtask

    // wait for every expected beat, then let the pipe settle
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pair_runs_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pair_runs_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", o_m_tdata, 0);
            end else begin
                run_expect = pair_runs_q.pop_front();
                if (o_m_tdata[PAIR_W-1:0] != run_expect.pair)
                    report_mismatch("pair_value", o_m_tdata[PAIR_W-1:0], run_expect.pair);
                if (o_m_tdata[PAIR_W+COUNT_W-1:PAIR_W] != run_expect.count)
                    report_mismatch("repeat_count", o_m_tdata[PAIR_W+COUNT_W-1:PAIR_W],
                                    run_expect.count);
                if (o_m_tlast != run_expect.done)
                    report_mismatch("plane_done", o_m_tlast, run_expect.done);
            end
        end
    end

    // cycles without any beat
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls and one long hold-off
    initial begin
        int held;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // stimulus
    initial begin
        int               ph;
        int               w;
        int               h;
        int               tries;
        int               ending;
        int               live_goal;
        bit               found;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_WIDTH_TILES;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        tx_gaps    = 1'b0;
        rx_stalls  = 1'b0;
        hold_req   = 1'b0;
        mismatches = 0;
        bits_live  = 0;

        // decoder copy after reset
        cfg_width        = RST_WIDTH_TILES;
        cfg_height       = RST_HEIGHT_TILES;
        cfg_run_first    = RST_FIRST_IS_RUN;
        plane_pairs_done = '0;
        run_packet_now   = RST_FIRST_IS_RUN;
        pkt_phase        = PH_HEAD;
        prefix_count     = '0;
        run_base         = '0;
        run_value        = '0;
        value_bits_due   = '0;
        first_pair_bit   = 1'b0;
        plane_complete   = 1'b0;
        stream_seen      = 1'b0;

        // opening table, direct packet first, 7x7 plane
        row_plain(1'b1); row_typed(1'b1, 2'b11, 13'd1);      // pair 11
        row_plain(1'b1); row_typed(1'b0, 2'b10, 13'd1);      // pair 10
        row_plain(1'b0); row_typed(1'b1, 2'b01, 13'd1);      // pair 01
        row_plain(1'b0); row_plain(1'b0);                    // 00 ends direct
        row_plain(1'b0); row_typed(1'b0, PAIR_ZERO, 13'd1);  // shortest run
        row_plain(1'b0); row_plain(1'b0);                    // empty direct packet
        row_plain(1'b0); row_typed(1'b1, PAIR_ZERO, 13'd2);  // run of two
        row_plain(1'b0); row_plain(1'b0);
        row_plain(1'b1); row_plain(1'b1); row_plain(1'b1); row_plain(1'b0);
        row_plain(1'b1); row_plain(1'b1); row_plain(1'b1);
        row_typed(1'b1, PAIR_ZERO, 13'd30);                  // three-one prefix, all-ones value
        row_plain(1'b0); row_plain(1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // loads the packet kind since no bit was taken yet
        cfg_write(REG_FIRST_IS_RUN, '0);

        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        foreach (opening_rows[i])
            send_bit(opening_rows[i].b, opening_rows[i].typed, opening_rows[i].want);

        // random phases under several plane sizes
        live_goal = bits_live;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            wv = 4'd15;
            hv = 4'd15;
            if (ph != 0) begin
                for (tries = 0; tries < 20; tries++) begin
                    w = $urandom_range(1, 15);
                    h = $urandom_range(1, 15);
                    if (w * h * PAIRS_PER_TILE >= int'(plane_pairs_done) + 900) begin
                        wv = CFG_W'(w);
                        hv = CFG_W'(h);
                        break;
                    end
                end
            end
            cfg_write(REG_WIDTH_TILES, wv);
            cfg_write(REG_HEIGHT_TILES, hv);
            // no effect once the stream has started
            if (ph == 2)
                cfg_write(REG_FIRST_IS_RUN, CFG_W'($urandom_range(0, 1)));
            tx_gaps   = (ph != 3) && (ph != NUM_PHASES - 1);
            rx_stalls = (ph != 1) && (ph != NUM_PHASES - 1);
            if (ph == 2)
                hold_req = 1'b1;
            live_goal += PHASE_BITS;
            while (bits_live < live_goal && !plane_complete)
                send_packet();
        end

        // close the plane
        drain_results();
        ending = $urandom_range(0, 3);
        case (ending)
            0: begin
                // saturated prefix, clamped run
                align_to_run();
                repeat ($urandom_range(PREFIX_CAP + 1, PREFIX_CAP + 4)) send_bit(1'b1, 1'b0, '0);
                send_bit(1'b0, 1'b0, '0);
                repeat (PREFIX_CAP + 1) send_bit($urandom_range(0, 1), 1'b0, '0);
            end
            1: begin
                // plane shrunk below what is written
                cfg_write(REG_WIDTH_TILES, 4'd1);
                cfg_write(REG_HEIGHT_TILES, 4'd1);
            end
            2: begin
                // zero size
                cfg_write(REG_HEIGHT_TILES, '0);
            end
            default: begin
                // smallest width that still has room, at its smallest height, then fill it
                found = 1'b0;
                for (w = 1; w <= 15; w++) begin
                    for (h = 1; h <= 15; h++) begin
                        if (!found && w * h * PAIRS_PER_TILE > int'(plane_pairs_done)) begin
                            found = 1'b1;
                            wv = CFG_W'(w);
                            hv = CFG_W'(h);
                        end
                    end
                end
                if (found) begin
                    cfg_write(REG_WIDTH_TILES, wv);
                    cfg_write(REG_HEIGHT_TILES, hv);
                end
                while (!plane_complete)
                    send_packet();
            end
        endcase

        // bits after the plane is complete are dropped
        repeat (40) send_bit($urandom_range(0, 1), 1'b0, '0);

        drain_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
